// ===== sv/q16au_pkg.sv =====
// shared types and constants for the q16.16 arithmetic unit
package q16au_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned PROD_W = 64;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_MUL = 2'd2;
    localparam logic [1:0] KIND_DIV = 2'd3;

    localparam logic [DATA_W-1:0] MARK_OVF = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MAX_VAL  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MIN_VAL  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ONE_BIT  = 32'h0001_0000;
    localparam logic [47:0]       HALF_LSB = 48'h0000_0000_8000;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic dinit;
        logic align;
        logic top;
        logic step;
        logic rnd;
        logic set_ovf;
        logic wr;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic b_zero;
        logic align_go;
        logic bit_zero;
        logic dvs_top;
        logic div_go;
    } status_t;

endpackage

// ===== sv/q16_16_arith_unit.sv =====
// top level of the signed q16.16 arithmetic unit
// Signed Q16.16 add, subtract, multiply and divide, one operation per input
// beat and exactly one result beat for it. Overflow gives 0x80000000, which
// saturating mode replaces by the maximum or minimum value. One beat is in
// work at a time. Each beat is accepted and ends by writing the result
// register; multiply first loads the registered 32x32 multiplier (range check
// and rounding happen on the way into the result register), and divide runs
// the restoring divider, which stops after setup on a zero divisor and else
// doubles the divisor step by step (up to 15 doublings, or 16 when the
// quotient cannot fit), decides the alignment is done, develops the quotient
// bit by bit (up to 32 bits), sees the loop is over and applies the rounding
// increment. The result sits in an output register, so a new beat is accepted
// while the previous result still waits to be taken; a finished beat then
// holds in its last state until that register has been emptied.
module q16_16_arith_unit
    import q16au_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // input channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               kind,
    input  logic                     saturate,
    input  logic signed [DATA_W-1:0] operand_a,
    input  logic signed [DATA_W-1:0] operand_b,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] result
);

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: handshakes, operation dispatch, divider loop control
    q16au_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: operand capture, multiplier, divider registers, result register
    q16au_dpath u_dpath (
        .clk       (clk),
        .kind      (kind),
        .saturate  (saturate),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

// ===== sv/q16au_ctrl.sv =====
// controller state machine for the q16.16 arithmetic unit
module q16au_ctrl
    import q16au_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    output logic       out_valid,
    input  logic       out_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_DINIT = 8'b0000_0100,
        ST_ALIGN = 8'b0000_1000,
        ST_TOP   = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_RND   = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_fire;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    unique case (kind)
                        KIND_MUL: state_next = ST_MUL;
                        KIND_DIV: state_next = ST_DINIT;
                        default:  state_next = ST_FIN;
                    endcase
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_DINIT:
            begin
                cmd.dinit  = 1'b1;
                state_next = status.b_zero ? ST_FIN : ST_ALIGN;
            end
            ST_ALIGN:
            begin
                priority if (status.align_go)
                begin
                    cmd.align = 1'b1;
                end
                else if (status.bit_zero)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = ST_FIN;
                end
                else if (status.dvs_top)
                begin
                    state_next = ST_TOP;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_TOP:
            begin
                cmd.top    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_go)
                begin
                    cmd.step = 1'b1;
                end
                else
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                cmd.rnd    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.wr         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != ST_IDLE)
        else $error("accepted beat did not start work");

    a_wr_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> out_free)
        else $error("result written over an untaken beat");

    a_wr_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |=> out_valid_reg)
        else $error("written result not shown");

    a_align_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALIGN && !status.align_go && status.bit_zero)
        |=> state_reg == ST_FIN)
        else $error("alignment overflow did not finish the beat");

endmodule

// ===== sv/q16au_dpath.sv =====
// datapath for the q16.16 arithmetic unit: operands, multiplier, divider, result
module q16au_dpath
    import q16au_pkg::*;
(
    input  logic                     clk,
    input  logic [1:0]               kind,
    input  logic                     saturate,
    input  logic signed [DATA_W-1:0] operand_a,
    input  logic signed [DATA_W-1:0] operand_b,
    input  cmd_t                     cmd,
    output status_t                  status,
    output logic signed [DATA_W-1:0] result
);

    logic [1:0]               kind_reg;
    logic                     sat_reg;
    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W-1:0] b_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [DATA_W-1:0]        dvs_reg;
    logic [DATA_W-1:0]        quo_reg;
    logic [DATA_W-1:0]        bit_reg;
    logic                     ovf_reg;
    logic signed [DATA_W-1:0] result_reg;

    logic [DATA_W:0]   diff;
    logic              ge;
    logic [DATA_W-1:0] rem_sub;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] dif;
    logic              add_ovf;
    logic              sub_ovf;
    logic              mul_ovf;
    logic [47:0]       mul_t;
    logic [DATA_W-1:0] mul_r;
    logic [DATA_W-1:0] div_r;
    logic [DATA_W-1:0] raw;
    logic              up;
    logic [DATA_W-1:0] res_next;

    // divider compare and subtract share one wide subtractor
    assign diff    = {1'b0, rem_reg} - {1'b0, dvs_reg};
    assign ge      = !diff[DATA_W];
    assign rem_sub = ge ? diff[DATA_W-1:0] : rem_reg;

    assign status.b_zero   = (b_reg == '0);
    assign status.align_go = (bit_reg != '0) && (dvs_reg < rem_reg);
    assign status.bit_zero = (bit_reg == '0);
    assign status.dvs_top  = dvs_reg[DATA_W-1];
    assign status.div_go   = (bit_reg != '0) && (rem_reg != '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            sat_reg  <= saturate;
            a_reg    <= operand_a;
            b_reg    <= operand_b;
            ovf_reg  <= 1'b0;
        end
        if (cmd.mul)
        begin
            prod_reg <= a_reg * b_reg;
        end
        if (cmd.dinit)
        begin
            rem_reg <= a_reg[DATA_W-1] ? (32'd0 - a_reg) : a_reg;
            dvs_reg <= b_reg[DATA_W-1] ? (32'd0 - b_reg) : b_reg;
            quo_reg <= '0;
            bit_reg <= ONE_BIT;
            ovf_reg <= status.b_zero;
        end
        if (cmd.align)
        begin
            dvs_reg <= {dvs_reg[DATA_W-2:0], 1'b0};
            bit_reg <= {bit_reg[DATA_W-2:0], 1'b0};
        end
        if (cmd.top)
        begin
            rem_reg <= rem_sub;
            quo_reg <= ge ? (quo_reg | bit_reg) : quo_reg;
            dvs_reg <= {1'b0, dvs_reg[DATA_W-1:1]};
            bit_reg <= {1'b0, bit_reg[DATA_W-1:1]};
        end
        if (cmd.step)
        begin
            rem_reg <= {rem_sub[DATA_W-2:0], 1'b0};
            quo_reg <= ge ? (quo_reg | bit_reg) : quo_reg;
            bit_reg <= {1'b0, bit_reg[DATA_W-1:1]};
        end
        if (cmd.rnd)
        begin
            quo_reg <= quo_reg + {{(DATA_W-1){1'b0}}, ge};
        end
        if (cmd.set_ovf)
        begin
            ovf_reg <= 1'b1;
        end
        if (cmd.wr)
        begin
            result_reg <= res_next;
        end
    end

    always_comb
    begin
        sum     = a_reg + b_reg;
        dif     = a_reg - b_reg;
        add_ovf = !(a_reg[DATA_W-1] ^ b_reg[DATA_W-1]) && (a_reg[DATA_W-1] ^ sum[DATA_W-1]);
        sub_ovf = (a_reg[DATA_W-1] ^ b_reg[DATA_W-1]) && (a_reg[DATA_W-1] ^ dif[DATA_W-1]);

        // product must fit in 48 signed bits
        mul_ovf = !((&prod_reg[PROD_W-1:47]) || (~|prod_reg[PROD_W-1:47]));
        mul_t   = prod_reg[47:0] - HALF_LSB - {47'd0, prod_reg[PROD_W-1]};
        mul_r   = mul_t[47:16] + 32'd1;

        if (ovf_reg)
        begin
            div_r = MARK_OVF;
        end
        else if (a_reg[DATA_W-1] ^ b_reg[DATA_W-1])
        begin
            div_r = (quo_reg == MIN_VAL) ? MARK_OVF : (32'd0 - quo_reg);
        end
        else
        begin
            div_r = quo_reg;
        end

        unique case (kind_reg)
            KIND_ADD:
            begin
                raw = add_ovf ? MARK_OVF : sum;
                up  = !a_reg[DATA_W-1];
            end
            KIND_SUB:
            begin
                raw = sub_ovf ? MARK_OVF : dif;
                up  = !a_reg[DATA_W-1];
            end
            KIND_MUL:
            begin
                raw = mul_ovf ? MARK_OVF : mul_r;
                up  = (a_reg[DATA_W-1] == b_reg[DATA_W-1]);
            end
            default:
            begin
                raw = div_r;
                up  = (a_reg[DATA_W-1] == b_reg[DATA_W-1]);
            end
        endcase

        if (sat_reg && raw == MARK_OVF)
        begin
            res_next = up ? MAX_VAL : MIN_VAL;
        end
        else
        begin
            res_next = raw;
        end
    end

    assign result = result_reg;

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the q16.16 arithmetic unit
`timescale 1ns / 1ps

module testbench;

    import q16au_pkg::*;

    // a long receiver stall, ample for the slowest divide with the longest gaps on both sides
    localparam int STALL_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int DRAIN_CYCLES      = 60;

    // one accepted operation and the result it must produce
    typedef struct {
        logic [1:0]  op;
        logic        sat;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] res;
    } q16_beat_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               kind;
    logic                     saturate;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] result;

    q16_beat_t pending_results[$];

    // idling controls shared between the stimulus tasks and the result sink
    bit tx_idle_en    = 1'b1;
    bit rx_idle_en    = 1'b1;
    int stall_request = 0;

    // run statistics
    int mismatch_count  = 0;
    int results_checked = 0;
    int marker_results  = 0;
    int sat_beats       = 0;
    int beats_by_kind[4];

    q16_16_arith_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .saturate  (saturate),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // bit-exact prediction of one operation
    // ------------------------------------------------------------------

    function automatic logic [31:0] q16_expected_result(
        input logic [1:0]  op,
        input logic        sat,
        input logic [31:0] a,
        input logic [31:0] b
    );
        logic [31:0]        r;
        logic               up;
        logic signed [63:0] prod;
        logic [63:0]        biased;
        logic [31:0]        rem;
        logic [31:0]        dvs;
        logic [31:0]        quo;
        logic [31:0]        qbit;
        case (op)
            KIND_ADD:
            begin
                // wraps, marker when both signs agree and the sum's sign differs
                r = a + b;
                if (a[31] == b[31] && r[31] != a[31])
                    r = MARK_OVF;
                up = !a[31];
            end
            KIND_SUB:
            begin
                r = a - b;
                if (a[31] != b[31] && r[31] != a[31])
                    r = MARK_OVF;
                up = !a[31];
            end
            KIND_MUL:
            begin
                // full product must fit 48 signed bits, then the odd rounding step
                prod   = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                biased = prod + 64'h0000_8000_0000_0000;
                if (biased >= 64'h0001_0000_0000_0000)
                    r = MARK_OVF;
                else
                begin
                    prod = prod - {16'd0, HALF_LSB} - {63'd0, prod[63]};
                    r    = prod[47:16] + 32'd1;
                end
                up = (a[31] == b[31]);
            end
            default:
            begin
                up = (a[31] == b[31]);
                if (b == '0)
                    r = MIN_VAL;
                else
                begin
                    rem  = a[31] ? 32'd0 - a : a;
                    dvs  = b[31] ? 32'd0 - b : b;
                    quo  = '0;
                    qbit = ONE_BIT;
                    // line the divisor up with the dividend
                    while (qbit != '0 && dvs < rem)
                    begin
                        dvs  = dvs << 1;
                        qbit = qbit << 1;
                    end
                    if (qbit == '0)
                        r = MARK_OVF;
                    else
                    begin
                        // divisor top bit set: one step without shifting the remainder
                        if (dvs[31])
                        begin
                            if (rem >= dvs)
                            begin
                                quo = quo | qbit;
                                rem = rem - dvs;
                            end
                            dvs  = dvs >> 1;
                            qbit = qbit >> 1;
                        end
                        while (qbit != '0 && rem != '0)
                        begin
                            if (rem >= dvs)
                            begin
                                quo = quo | qbit;
                                rem = rem - dvs;
                            end
                            rem  = rem << 1;
                            qbit = qbit >> 1;
                        end
                        // final rounding increment
                        if (rem >= dvs)
                            quo = quo + 32'd1;
                        if (a[31] != b[31])
                            r = (quo == MIN_VAL) ? MARK_OVF : 32'd0 - quo;
                        else
                            r = quo;
                    end
                end
            end
        endcase
        // saturating mode clamps anything equal to the marker, genuine or not
        if (sat && r == MARK_OVF)
            r = up ? MAX_VAL : MIN_VAL;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    // idle stretch: mostly short, now and then long
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 2);
        else if (pick < 94)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    // operands biased towards the interesting regions of q16.16
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom();
            4, 5:
            begin
                // within about +/-8.0, so products and quotients mostly stay in range
                v = $urandom_range(0, 32'h0008_0000);
                if ($urandom_range(0, 1) == 1)
                    v = 32'd0 - v;
            end
            6: v = MAX_VAL - $urandom_range(0, 32'h0001_FFFF);
            7: v = MIN_VAL + $urandom_range(0, 32'h0001_FFFF);
            default:
            begin
                case ($urandom_range(0, 7))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'hFFFF_FFFF;
                    3: v = ONE_BIT;
                    4: v = 32'd0 - ONE_BIT;
                    5: v = MAX_VAL;
                    6: v = MIN_VAL;
                    default: v = 32'h0000_8000;
                endcase
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // input side: one beat, driven at the falling edge
    // ------------------------------------------------------------------

    task automatic send_op(
        input logic [1:0]  op,
        input logic        sat,
        input logic [31:0] a,
        input logic [31:0] b
    );
        q16_beat_t beat;
        int        gap;
        @(negedge clk);
        in_valid  <= 1'b1;
        kind      <= op;
        saturate  <= sat;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted at this edge
        beat.op  = op;
        beat.sat = sat;
        beat.a   = a;
        beat.b   = b;
        beat.res = q16_expected_result(op, sat, a, b);
        pending_results.push_back(beat);
        beats_by_kind[op]++;
        if (sat)
            sat_beats++;
        // valid stays high when the next beat follows straight on
        gap = (!tx_idle_en || $urandom_range(0, 99) < 55) ? 0 : idle_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // drop valid so that a held beat is not taken twice
    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_add_sub_corners();
        send_op(KIND_ADD, 1'b0, MAX_VAL, 32'h0000_0001);
        send_op(KIND_ADD, 1'b1, MAX_VAL, 32'h0000_0001);
        send_op(KIND_ADD, 1'b1, MIN_VAL, 32'hFFFF_FFFF);
        // two negatives summing exactly to the marker value
        send_op(KIND_ADD, 1'b1, 32'hC000_0000, 32'hC000_0000);
        send_op(KIND_SUB, 1'b0, 32'h0000_0000, MIN_VAL);
        send_op(KIND_SUB, 1'b1, 32'h0000_0000, MIN_VAL);
        send_op(KIND_SUB, 1'b1, MIN_VAL, 32'h0000_0000);
        send_op(KIND_SUB, 1'b0, 32'h0001_8000, 32'hFFFF_4000);
        release_input();
    endtask

    task automatic test_mul_corners();
        send_op(KIND_MUL, 1'b0, ONE_BIT, ONE_BIT);
        send_op(KIND_MUL, 1'b0, 32'hFFFF_0000, ONE_BIT);
        send_op(KIND_MUL, 1'b1, MAX_VAL, MAX_VAL);
        send_op(KIND_MUL, 1'b1, MIN_VAL, MAX_VAL);
        send_op(KIND_MUL, 1'b0, MIN_VAL, MIN_VAL);
        // rounding of a half lsb, positive and negative
        send_op(KIND_MUL, 1'b0, 32'h0000_0001, 32'h0000_8000);
        send_op(KIND_MUL, 1'b0, 32'hFFFF_FFFF, 32'h0000_8000);
        // minimum times one lands on the marker without overflow
        send_op(KIND_MUL, 1'b1, MIN_VAL, ONE_BIT);
        release_input();
    endtask

    task automatic test_div_corners();
        // zero divisor, plain and clamped both ways
        send_op(KIND_DIV, 1'b0, ONE_BIT, 32'h0000_0000);
        send_op(KIND_DIV, 1'b1, ONE_BIT, 32'h0000_0000);
        send_op(KIND_DIV, 1'b1, 32'hFFFF_0000, 32'h0000_0000);
        send_op(KIND_DIV, 1'b0, ONE_BIT, 32'h0003_0000);
        // sixteen doublings needed: quotient cannot fit
        send_op(KIND_DIV, 1'b0, MAX_VAL, 32'h0000_0001);
        // quotient magnitude 2^31, negative then positive
        send_op(KIND_DIV, 1'b1, MIN_VAL, ONE_BIT);
        send_op(KIND_DIV, 1'b1, MIN_VAL, 32'hFFFF_0000);
        send_op(KIND_DIV, 1'b0, 32'hFFFE_0000, 32'h0004_0000);
        send_op(KIND_DIV, 1'b0, 32'h0000_0001, MAX_VAL);
        release_input();
    endtask

    task automatic test_random_mix(input int count);
        logic [1:0] op;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (count)
        begin
            op = 2'($urandom_range(KIND_ADD, KIND_DIV));
            send_op(op, 1'($urandom_range(0, 1)), pick_operand(), pick_operand());
        end
        release_input();
    endtask

    // no idling on either side
    task automatic test_back_to_back(input int count);
        logic [1:0] op;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (count)
        begin
            op = 2'($urandom_range(KIND_ADD, KIND_DIV));
            send_op(op, 1'($urandom_range(0, 1)), pick_operand(), pick_operand());
        end
        release_input();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // receiver holds off for a long stretch while beats keep coming
    task automatic test_output_stall(input int count);
        logic [1:0] op;
        tx_idle_en    = 1'b0;
        stall_request = STALL_HOLD_CYCLES;
        repeat (count)
        begin
            op = 2'($urandom_range(KIND_ADD, KIND_DIV));
            send_op(op, 1'($urandom_range(0, 1)), pick_operand(), pick_operand());
        end
        release_input();
        tx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // result side: ready driven at the falling edge, its own stall count
    // ------------------------------------------------------------------

    initial
    begin : result_sink
        int gap_left;
        gap_left  = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request > 0)
            begin
                gap_left      = stall_request;
                stall_request = 0;
            end
            else if (gap_left == 0 && rx_idle_en && $urandom_range(0, 3) == 0)
                gap_left = idle_gap();
            if (gap_left > 0)
            begin
                out_ready <= 1'b0;
                gap_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // compare every result beat with the oldest outstanding expectation
    always @(posedge clk)
    begin : result_check
        q16_beat_t beat;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h with no beat outstanding", $time, result);
                mismatch_count++;
            end
            else
            begin
                beat = pending_results.pop_front();
                results_checked++;
                if (result === MARK_OVF)
                    marker_results++;
                if (result !== beat.res)
                begin
                    $display("%0t: result mismatch, kind %0d sat %0d a %h b %h: expected %h, got %h",
                             $time, beat.op, beat.sat, beat.a, beat.b, beat.res, result);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: cycles with work outstanding but no beat moving on either side
    always @(posedge clk)
    begin : watchdog
        int stuck_cycles;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (!in_valid && pending_results.size() == 0))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no beat accepted for %0d cycles", $time, stuck_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_ADD;
        saturate  = 1'b0;
        operand_a = '0;
        operand_b = '0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_add_sub_corners();
        test_mul_corners();
        test_div_corners();
        test_random_mix(300);
        test_back_to_back(80);
        test_output_stall(40);
        test_random_mix(160);

        // let every outstanding result arrive, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("covered %0d add, %0d subtract, %0d multiply, %0d divide beats, %0d saturating",
                 beats_by_kind[KIND_ADD], beats_by_kind[KIND_SUB],
                 beats_by_kind[KIND_MUL], beats_by_kind[KIND_DIV], sat_beats);
        $display("checked %0d results, %0d of them overflow markers, %0d mismatches",
                 results_checked, marker_results, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/q16au_pkg.sv
sv/q16au_ctrl.sv
sv/q16au_dpath.sv
sv/q16_16_arith_unit.sv
verif/testbench.sv
